// ===== design/kmc_pkg.sv =====
`default_nettype none

package kmc_pkg;

    // default sizes of the stores
    localparam int DEF_MAX_ROWS     = 16;
    localparam int DEF_MAX_COLUMNS  = 64;
    localparam int DEF_MAX_CLUSTERS = 8;

    // field widths
    localparam int FUNC_W = 2;
    localparam int COL_W  = 6;
    localparam int ROW_W  = 4;
    localparam int VAL_W  = 16;
    localparam int CTR_W  = 3;
    localparam int CLU_W  = 3;
    localparam int RND_W  = 8;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    // item kinds
    localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SEED = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RUN  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IT  = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic load_we;
        logic seed_latch;
        logic run_init;
        logic round_init;
        logic s_clr;
        logic s_inc;
        logic k_clr;
        logic k_inc;
        logic g_clr;
        logic g_inc;
        logic best_clr;
        logic acc_clr;
        logic a_acc;
        logic a_cmp;
        logic l_wr;
        logic z_clr;
        logic sum_clr;
        logic u_add;
        logic u_gend;
        logic u_inval;
        logic div_start;
        logic c_wr;
        logic c_seed;
        logic seed_done;
        logic round_end;
        logic o_ld;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic ok_load;
        logic ok_seed;
        logic g_last;
        logic g_seed_last;
        logic s_last;
        logic k_end;
        logic k_valid;
        logic z_zero;
        logic div_busy;
        logic again;
    } t_sts;

endpackage

`default_nettype wire

// ===== design/kmc_ram.sv =====
`default_nettype none

module kmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/kmc_div.sv =====
`default_nettype none

module kmc_div #(
    parameter int NUM_W = 8,
    parameter int DEN_W = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_busy,
    output logic      [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W:0]   trial;
    logic             ge;

    // one quotient bit per cycle, restoring
    assign trial = {r_rem, r_q[NUM_W-1]};
    assign ge    = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? DEN_W'(trial - {1'b0, r_den}) : DEN_W'(trial);
            r_q   <= {r_q[NUM_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

`default_nettype wire

// ===== design/kmc_ctrl.sv =====
`default_nettype none

module kmc_ctrl import kmc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [FUNC_W-1:0] i_func,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire t_sts              i_sts,
    output t_cmd                   o_cmd
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_SRD   = 5'd1;
    localparam logic [4:0] ST_SWR   = 5'd2;
    localparam logic [4:0] ST_ACOL  = 5'd3;
    localparam logic [4:0] ST_AKCHK = 5'd4;
    localparam logic [4:0] ST_ARD   = 5'd5;
    localparam logic [4:0] ST_ADIF  = 5'd6;
    localparam logic [4:0] ST_AACC  = 5'd7;
    localparam logic [4:0] ST_ACMP  = 5'd8;
    localparam logic [4:0] ST_UK    = 5'd9;
    localparam logic [4:0] ST_UG    = 5'd10;
    localparam logic [4:0] ST_URD   = 5'd11;
    localparam logic [4:0] ST_UADD  = 5'd12;
    localparam logic [4:0] ST_UGEND = 5'd13;
    localparam logic [4:0] ST_UZCHK = 5'd14;
    localparam logic [4:0] ST_UDRD  = 5'd15;
    localparam logic [4:0] ST_UDST  = 5'd16;
    localparam logic [4:0] ST_UDIV  = 5'd17;
    localparam logic [4:0] ST_REND  = 5'd18;
    localparam logic [4:0] ST_RCHK  = 5'd19;
    localparam logic [4:0] ST_ORD   = 5'd20;
    localparam logic [4:0] ST_OLD   = 5'd21;
    localparam logic [4:0] ST_OWAIT = 5'd22;

    logic [4:0] r_state;
    logic [4:0] n_state;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OWAIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_func)
                        FUNC_LOAD: begin
                            o_cmd.load_we = i_sts.ok_load;
                        end
                        FUNC_SEED: begin
                            if (i_sts.ok_seed) begin
                                o_cmd.seed_latch = 1'b1;
                                n_state = ST_SRD;
                            end
                        end
                        FUNC_RUN: begin
                            o_cmd.run_init = 1'b1;
                            o_cmd.s_clr    = 1'b1;
                            n_state = ST_ACOL;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // seed copies one row at a time, a read state then a write state
            ST_SRD: n_state = ST_SWR;
            ST_SWR: begin
                o_cmd.c_wr   = 1'b1;
                o_cmd.c_seed = 1'b1;
                if (i_sts.g_seed_last) begin
                    o_cmd.seed_done = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.g_inc = 1'b1;
                    n_state = ST_SRD;
                end
            end
            // assignment: per column, scan centers
            ST_ACOL: begin
                o_cmd.best_clr = 1'b1;
                o_cmd.k_clr    = 1'b1;
                n_state = ST_AKCHK;
            end
            ST_AKCHK: begin
                if (i_sts.k_end) begin
                    o_cmd.l_wr = 1'b1;
                    if (i_sts.s_last) begin
                        o_cmd.k_clr = 1'b1;
                        n_state = ST_UK;
                    end else begin
                        o_cmd.s_inc = 1'b1;
                        n_state = ST_ACOL;
                    end
                end else if (!i_sts.k_valid) begin
                    o_cmd.k_inc = 1'b1;
                end else begin
                    o_cmd.g_clr   = 1'b1;
                    o_cmd.acc_clr = 1'b1;
                    n_state = ST_ARD;
                end
            end
            ST_ARD:  n_state = ST_ADIF;
            ST_ADIF: n_state = ST_AACC;
            ST_AACC: begin
                o_cmd.a_acc = 1'b1;
                if (i_sts.g_last) begin
                    n_state = ST_ACMP;
                end else begin
                    o_cmd.g_inc = 1'b1;
                    n_state = ST_ARD;
                end
            end
            ST_ACMP: begin
                o_cmd.a_cmp = 1'b1;
                o_cmd.k_inc = 1'b1;
                n_state = ST_AKCHK;
            end
            // update: row sums per center, then normalize
            ST_UK: begin
                if (i_sts.k_end) begin
                    n_state = ST_REND;
                end else begin
                    o_cmd.z_clr = 1'b1;
                    o_cmd.g_clr = 1'b1;
                    n_state = ST_UG;
                end
            end
            ST_UG: begin
                o_cmd.sum_clr = 1'b1;
                o_cmd.s_clr   = 1'b1;
                n_state = ST_URD;
            end
            ST_URD: n_state = ST_UADD;
            ST_UADD: begin
                o_cmd.u_add = 1'b1;
                if (i_sts.s_last) begin
                    n_state = ST_UGEND;
                end else begin
                    o_cmd.s_inc = 1'b1;
                    n_state = ST_URD;
                end
            end
            ST_UGEND: begin
                o_cmd.u_gend = 1'b1;
                if (i_sts.g_last) begin
                    n_state = ST_UZCHK;
                end else begin
                    o_cmd.g_inc = 1'b1;
                    n_state = ST_UG;
                end
            end
            ST_UZCHK: begin
                if (i_sts.z_zero) begin
                    o_cmd.u_inval = 1'b1;
                    o_cmd.k_inc   = 1'b1;
                    n_state = ST_UK;
                end else begin
                    o_cmd.g_clr = 1'b1;
                    n_state = ST_UDRD;
                end
            end
            ST_UDRD: n_state = ST_UDST;
            ST_UDST: begin
                o_cmd.div_start = 1'b1;
                n_state = ST_UDIV;
            end
            ST_UDIV: begin
                if (!i_sts.div_busy) begin
                    o_cmd.c_wr = 1'b1;
                    if (i_sts.g_last) begin
                        o_cmd.k_inc = 1'b1;
                        n_state = ST_UK;
                    end else begin
                        o_cmd.g_inc = 1'b1;
                        n_state = ST_UDRD;
                    end
                end
            end
            // end of round
            ST_REND: begin
                o_cmd.round_end = 1'b1;
                n_state = ST_RCHK;
            end
            ST_RCHK: begin
                o_cmd.s_clr = 1'b1;
                if (i_sts.again) begin
                    o_cmd.round_init = 1'b1;
                    n_state = ST_ACOL;
                end else begin
                    n_state = ST_ORD;
                end
            end
            // label output, one transfer per column
            ST_ORD: n_state = ST_OLD;
            ST_OLD: begin
                o_cmd.o_ld = 1'b1;
                n_state = ST_OWAIT;
            end
            ST_OWAIT: begin
                if (i_out_ready) begin
                    if (i_sts.s_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.s_inc = 1'b1;
                        n_state = ST_ORD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/kmc_dp.sv =====
`default_nettype none

module kmc_dp import kmc_pkg::*; #(
    parameter int MAX_ROWS     = DEF_MAX_ROWS,
    parameter int MAX_COLUMNS  = DEF_MAX_COLUMNS,
    parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_sts                       o_sts,
    input  wire logic [COL_W-1:0]      i_column_index,
    input  wire logic [ROW_W-1:0]      i_row_index,
    input  wire logic [VAL_W-1:0]      i_element_value,
    input  wire logic [CTR_W-1:0]      i_center_index,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic      [COL_W-1:0]      o_out_column,
    output logic      [CLU_W-1:0]      o_out_cluster,
    output logic                       o_converged,
    output logic      [RND_W-1:0]      o_rounds_used,
    output logic                       o_last
);

    localparam int G_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int S_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int K_W   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int R_CW  = $clog2(MAX_ROWS + 1);
    localparam int C_CW  = $clog2(MAX_COLUMNS + 1);
    localparam int K_CW  = $clog2(MAX_CLUSTERS + 1);
    localparam int DA_D  = MAX_COLUMNS * MAX_ROWS;
    localparam int CA_D  = MAX_CLUSTERS * MAX_ROWS;
    localparam int DA_W  = (DA_D > 1) ? $clog2(DA_D) : 1;
    localparam int CA_W  = (CA_D > 1) ? $clog2(CA_D) : 1;
    localparam int SUM_W = VAL_W + C_CW;
    localparam int Z_W   = SUM_W + R_CW;
    localparam int NUM_W = Z_W + 17;
    localparam int D_W   = 32 + R_CW;

    // raw configuration
    logic [4:0]           r_cfg_rows;
    logic [6:0]           r_cfg_cols;
    logic [3:0]           r_cfg_kk;
    logic [7:0]           r_cfg_it;
    // clamped run bounds
    logic [R_CW-1:0]      r_rows;
    logic [C_CW-1:0]      r_cols;
    logic [K_CW-1:0]      r_kk;
    logic [RND_W-1:0]     r_cap;
    logic [R_CW-1:0]      rows_c;
    logic [C_CW-1:0]      cols_c;
    logic [K_CW-1:0]      kk_c;

    logic [S_W-1:0]       r_s;
    logic [G_W-1:0]       r_g;
    logic [K_CW-1:0]      r_k;
    logic [MAX_CLUSTERS-1:0] r_valid;
    logic [RND_W-1:0]     r_round;
    logic                 r_changed;
    logic                 r_first;

    logic [31:0]          r_diff;
    logic [D_W-1:0]       r_acc;
    logic [D_W-1:0]       r_best_d;
    logic [K_W-1:0]       r_best;
    logic                 r_found;
    logic [SUM_W-1:0]     r_sum;
    logic [Z_W-1:0]       r_z;

    logic [VAL_W-1:0]     drd;
    logic [31:0]          crd;
    logic [K_W-1:0]       lrd;
    logic [SUM_W-1:0]     rbd;
    logic [31:0]          a_val;
    logic [K_W-1:0]       old_lbl;
    logic [DA_W-1:0]      da_waddr;
    logic [DA_W-1:0]      da_raddr;
    logic [CA_W-1:0]      ca_addr;
    logic [31:0]          c_wdata;
    logic [NUM_W-1:0]     div_num;
    logic [NUM_W-1:0]     quot;
    logic                 div_busy;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rows <= 5'd16;
            r_cfg_cols <= 7'd64;
            r_cfg_kk   <= 4'd8;
            r_cfg_it   <= 8'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROWS:    r_cfg_rows <= i_cfg_data[4:0];
                CFG_COLUMNS: r_cfg_cols <= i_cfg_data[6:0];
                CFG_CLUSTER: r_cfg_kk   <= i_cfg_data[3:0];
                CFG_MAX_IT:  r_cfg_it   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // clamp to the supported ranges
    always_comb begin
        if (r_cfg_rows == '0) begin
            rows_c = R_CW'(1);
        end else if (int'(r_cfg_rows) > MAX_ROWS) begin
            rows_c = R_CW'(MAX_ROWS);
        end else begin
            rows_c = R_CW'(r_cfg_rows);
        end
        if (r_cfg_cols == '0) begin
            cols_c = C_CW'(1);
        end else if (int'(r_cfg_cols) > MAX_COLUMNS) begin
            cols_c = C_CW'(MAX_COLUMNS);
        end else begin
            cols_c = C_CW'(r_cfg_cols);
        end
        if (r_cfg_kk == '0) begin
            kk_c = K_CW'(1);
        end else if (int'(r_cfg_kk) > MAX_CLUSTERS) begin
            kk_c = K_CW'(MAX_CLUSTERS);
        end else begin
            kk_c = K_CW'(r_cfg_kk);
        end
    end

    // run control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows    <= R_CW'(1);
            r_cols    <= C_CW'(1);
            r_kk      <= K_CW'(1);
            r_cap     <= 8'd1;
            r_round   <= '0;
            r_changed <= 1'b0;
            r_first   <= 1'b1;
            r_valid   <= '1;
        end else begin
            if (i_cmd.run_init) begin
                r_rows    <= rows_c;
                r_cols    <= cols_c;
                r_kk      <= kk_c;
                r_cap     <= (r_cfg_it == '0) ? 8'd1 : r_cfg_it;
                r_round   <= '0;
                r_changed <= 1'b0;
                r_first   <= 1'b1;
            end
            if (i_cmd.round_init) begin
                r_changed <= 1'b0;
                r_first   <= 1'b0;
            end
            if (i_cmd.round_end) begin
                r_round <= r_round + 8'd1;
            end
            if (i_cmd.l_wr && (r_best != old_lbl)) begin
                r_changed <= 1'b1;
            end
            if (i_cmd.u_inval) begin
                r_valid[r_k[K_W-1:0]] <= 1'b0;
            end
            if (i_cmd.seed_done) begin
                r_valid[r_k[K_W-1:0]] <= 1'b1;
            end
        end
    end

    // loop counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_latch) begin
            r_s <= S_W'(i_column_index);
            r_k <= K_CW'(i_center_index);
            r_g <= '0;
        end else begin
            if (i_cmd.s_clr) begin
                r_s <= '0;
            end else if (i_cmd.s_inc) begin
                r_s <= r_s + S_W'(1);
            end
            if (i_cmd.k_clr) begin
                r_k <= '0;
            end else if (i_cmd.k_inc) begin
                r_k <= r_k + K_CW'(1);
            end
            if (i_cmd.g_clr) begin
                r_g <= '0;
            end else if (i_cmd.g_inc) begin
                r_g <= r_g + G_W'(1);
            end
        end
    end

    // store addresses
    assign da_waddr = DA_W'(int'(i_column_index) * MAX_ROWS + int'(i_row_index));
    assign da_raddr = DA_W'(int'(r_s) * MAX_ROWS + int'(r_g));
    assign ca_addr  = CA_W'(int'(r_k[K_W-1:0]) * MAX_ROWS + int'(r_g));
    assign c_wdata  = i_cmd.c_seed ? {drd, 16'h0000} : quot[31:0];

    kmc_ram #(.WIDTH(VAL_W), .DEPTH(DA_D)) u_data (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_we),
        .i_waddr (da_waddr),
        .i_wdata (i_element_value),
        .i_raddr (da_raddr),
        .o_rdata (drd)
    );

    kmc_ram #(.WIDTH(32), .DEPTH(CA_D)) u_center (
        .i_clk   (i_clk),
        .i_we    (i_cmd.c_wr),
        .i_waddr (ca_addr),
        .i_wdata (c_wdata),
        .i_raddr (ca_addr),
        .o_rdata (crd)
    );

    kmc_ram #(.WIDTH(K_W), .DEPTH(MAX_COLUMNS)) u_label (
        .i_clk   (i_clk),
        .i_we    (i_cmd.l_wr),
        .i_waddr (r_s),
        .i_wdata (r_best),
        .i_raddr (r_s),
        .o_rdata (lrd)
    );

    kmc_ram #(.WIDTH(SUM_W), .DEPTH(MAX_ROWS)) u_rowsum (
        .i_clk   (i_clk),
        .i_we    (i_cmd.u_gend),
        .i_waddr (r_g),
        .i_wdata (r_sum),
        .i_raddr (r_g),
        .o_rdata (rbd)
    );

    // labels read as zero in the first round of a run
    assign old_lbl = r_first ? '0 : lrd;
    assign a_val   = {drd, 16'h0000};

    // distance, nearest center and row sums
    always_ff @(posedge i_clk) begin
        r_diff <= (a_val >= crd) ? (a_val - crd) : (crd - a_val);
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.a_acc) begin
            r_acc <= r_acc + D_W'(r_diff);
        end
        if (i_cmd.best_clr) begin
            r_found <= 1'b0;
            r_best  <= '0;
        end else if (i_cmd.a_cmp && (!r_found || (r_acc < r_best_d))) begin
            r_found  <= 1'b1;
            r_best_d <= r_acc;
            r_best   <= r_k[K_W-1:0];
        end
        if (i_cmd.sum_clr) begin
            r_sum <= '0;
        end else if (i_cmd.u_add && (K_CW'(lrd) == r_k)) begin
            r_sum <= r_sum + SUM_W'(drd);
        end
        if (i_cmd.z_clr) begin
            r_z <= '0;
        end else if (i_cmd.u_gend) begin
            r_z <= r_z + Z_W'(r_sum);
        end
    end

    // rounded normalization of one center row
    assign div_num = NUM_W'({rbd, 16'h0000}) + NUM_W'(r_z >> 1);

    kmc_div #(.NUM_W(NUM_W), .DEN_W(Z_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (r_z),
        .o_busy  (div_busy),
        .o_quot  (quot)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.o_ld) begin
            o_out_column  <= COL_W'(r_s);
            o_out_cluster <= CLU_W'(lrd);
            o_converged   <= !r_changed;
            o_rounds_used <= r_round;
            o_last        <= o_sts.s_last;
        end
    end

    // status
    assign o_sts.ok_load     = (int'(i_column_index) < MAX_COLUMNS) &&
                               (int'(i_row_index) < MAX_ROWS);
    assign o_sts.ok_seed     = (int'(i_column_index) < MAX_COLUMNS) &&
                               (int'(i_center_index) < MAX_CLUSTERS);
    assign o_sts.g_last      = ((R_CW'(r_g) + R_CW'(1)) == r_rows);
    assign o_sts.g_seed_last = (int'(r_g) == MAX_ROWS - 1);
    assign o_sts.s_last      = ((C_CW'(r_s) + C_CW'(1)) == r_cols);
    assign o_sts.k_end       = (r_k == r_kk);
    assign o_sts.k_valid     = r_valid[r_k[K_W-1:0]];
    assign o_sts.z_zero      = (r_z == '0);
    assign o_sts.div_busy    = div_busy;
    assign o_sts.again       = r_changed && (r_round < r_cap);

endmodule

`default_nettype wire

// ===== design/kmeans_l1_normalized_clusterer.sv =====
// load item: a new item every cycle
// seed item: copies every row, a read state and a write state per row, bound by the single data store read port
// run item: per round an assignment pass over the columns and centers, then an update
//   pass over the centers and rows with the serial divider, then one transfer per reported column
// reset: synchronous active-low; registers back to 16, 64, 8, 64, all centers valid
`default_nettype none

module kmeans_l1_normalized_clusterer import kmc_pkg::*; #(
    parameter int MAX_ROWS     = DEF_MAX_ROWS,
    parameter int MAX_COLUMNS  = DEF_MAX_COLUMNS,
    parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    // column_index[5:0], row_index[9:6], element_value[25:10], center_index[28:26]
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    // func[1:0]
    input  wire logic [FUNC_W-1:0]      i_s_tuser,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    // out_column[5:0], out_cluster[8:6], converged[9], rounds_used[17:10]
    output logic      [OUT_TDATA_W-1:0] o_m_tdata,
    output logic                        o_m_tlast,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cmd             cmd;
    t_sts             sts;
    logic [COL_W-1:0] out_column;
    logic [CLU_W-1:0] out_cluster;
    logic             converged;
    logic [RND_W-1:0] rounds_used;

    assign o_cfg_ready = 1'b1;

    kmc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .i_func      (i_s_tuser),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    kmc_dp #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_COLUMNS  (MAX_COLUMNS),
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_column_index  (i_s_tdata[5:0]),
        .i_row_index     (i_s_tdata[9:6]),
        .i_element_value (i_s_tdata[25:10]),
        .i_center_index  (i_s_tdata[28:26]),
        .i_cfg_we        (i_cfg_valid & o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_out_column    (out_column),
        .o_out_cluster   (out_cluster),
        .o_converged     (converged),
        .o_rounds_used   (rounds_used),
        .o_last          (o_m_tlast)
    );

    // pack result fields
    assign o_m_tdata = {6'b0, rounds_used, converged, out_cluster, out_column};

endmodule

`default_nettype wire

// ===== bench/tb_kmeans_l1_normalized_clusterer.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tb_kmeans_l1_normalized_clusterer;
    import kmc_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
    localparam int NR = DEF_MAX_ROWS;
    localparam int NC = DEF_MAX_COLUMNS;
    localparam int NK = DEF_MAX_CLUSTERS;
    // columns that are loaded in full before any seed or run
    localparam int NFILL = 8;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [VAL_W-1:0]  val;
        logic [CTR_W-1:0]  ctr;
    } t_item;

    typedef struct {
        logic [COL_W-1:0] col;
        logic [CLU_W-1:0] cluster;
        logic             conv;
        logic [RND_W-1:0] rounds;
        logic             last;
    } t_label;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic [FUNC_W-1:0]      i_s_tuser = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tlast;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    kmeans_l1_normalized_clusterer dut (.*);

    // mirror of the block state
    logic [15:0] data_mem [NC][NR];
    logic [31:0] center_mem [NK][NR];
    bit          center_ok [NK];
    logic [2:0]  label_mem [NC];
    logic [7:0]  reg_rows, reg_cols, reg_clusters, reg_max_it;

    t_item  pending_items[$];
    t_label expected_labels[$];
    int     mismatches = 0;
    int     labels_seen = 0;
    bit     no_idle = 0;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    // full clustering run, queues one label per column
    function automatic void predict_clustering();
        int rows, cols, kk, cap, rounds, best;
        bit changed, found;
        longint unsigned acc [NK][NR];
        longint unsigned d, bd, z, a, b;
        t_label lab;
        rows = clamp(reg_rows, 1, NR);
        cols = clamp(reg_cols, 1, NC);
        kk = clamp(reg_clusters, 1, NK);
        cap = clamp(reg_max_it, 1, 255);
        foreach (label_mem[s]) label_mem[s] = 0;
        rounds = 0;
        do begin
            // assignment to nearest valid center
            changed = 0;
            for (int s = 0; s < cols; s++) begin
                best = 0;
                bd = 0;
                found = 0;
                for (int k = 0; k < kk; k++) begin
                    if (!center_ok[k]) continue;
                    d = 0;
                    for (int g = 0; g < rows; g++) begin
                        a = longint'(data_mem[s][g]) << 16;
                        b = center_mem[k][g];
                        d += (a >= b) ? a - b : b - a;
                    end
                    if (!found || d < bd) begin
                        found = 1;
                        bd = d;
                        best = k;
                    end
                end
                if (best != label_mem[s]) begin
                    changed = 1;
                    label_mem[s] = CLU_W'(best);
                end
            end
            // center update with normalization
            for (int k = 0; k < NK; k++)
                for (int g = 0; g < NR; g++) acc[k][g] = 0;
            for (int s = 0; s < cols; s++)
                for (int g = 0; g < rows; g++)
                    acc[label_mem[s]][g] += data_mem[s][g];
            for (int k = 0; k < kk; k++) begin
                z = 0;
                for (int g = 0; g < rows; g++) z += acc[k][g];
                if (z == 0) begin
                    center_ok[k] = 0;
                    continue;
                end
                for (int g = 0; g < rows; g++)
                    center_mem[k][g] = 32'(((acc[k][g] << 16) + z / 2) / z);
            end
            rounds++;
        end while (changed && rounds < cap);
        for (int s = 0; s < cols; s++) begin
            lab.col = COL_W'(s);
            lab.cluster = label_mem[s];
            lab.conv = !changed;
            lab.rounds = RND_W'(rounds);
            lab.last = (s == cols - 1);
            expected_labels.insert(expected_labels.size(), lab);
        end
    endfunction

    function automatic void predict_item(t_item it);
        case (it.func)
            FUNC_LOAD: data_mem[it.col][it.row] = it.val;
            FUNC_SEED: begin
                for (int g = 0; g < NR; g++)
                    center_mem[it.ctr][g] = {data_mem[it.col][g], 16'h0};
                center_ok[it.ctr] = 1;
            end
            FUNC_RUN: predict_clustering();
            default: ;
        endcase
    endfunction

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 0;
            i_s_tdata <= '0;
            i_s_tuser <= '0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                predict_item(pending_items[0]);
                void'(pending_items.pop_front());
            end
            if (i_s_tvalid && !o_s_tready) begin
                // hold current transfer
            end else if (pending_items.size() > 0 &&
                         (no_idle || $urandom_range(99) >= 35)) begin
                i_s_tvalid <= 1;
                i_s_tuser <= pending_items[0].func;
                i_s_tdata <= {3'b0, pending_items[0].ctr, pending_items[0].val,
                              pending_items[0].row, pending_items[0].col};
            end else begin
                i_s_tvalid <= 0;
            end
        end
    end

    // output monitor and checker
    always @(posedge i_clk) begin
        t_label got, want;
        if (!i_rst_n) begin
            i_m_tready <= 0;
        end else begin
            i_m_tready <= no_idle || ($urandom_range(99) >= 35);
            if (o_m_tvalid && i_m_tready) begin
                got.col = o_m_tdata[5:0];
                got.cluster = o_m_tdata[8:6];
                got.conv = o_m_tdata[9];
                got.rounds = o_m_tdata[17:10];
                got.last = o_m_tlast;
                labels_seen++;
                if (expected_labels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected label transfer: col %0d cluster %0d",
                                 got.col, got.cluster);
                end else begin
                    want = expected_labels.pop_front();
                    if (got.col !== want.col || got.cluster !== want.cluster ||
                        got.conv !== want.conv || got.rounds !== want.rounds ||
                        got.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"label mismatch: expected col %0d cl %0d conv %0d",
                                      " rnd %0d last %0d, got col %0d cl %0d conv %0d",
                                      " rnd %0d last %0d"},
                                     want.col, want.cluster, want.conv, want.rounds,
                                     want.last, got.col, got.cluster, got.conv,
                                     got.rounds, got.last);
                    end
                end
            end
        end
    end

    task automatic push_item(logic [1:0] f, int c, int r, int v, int k);
        t_item it;
        it.func = f;
        it.col = COL_W'(c);
        it.row = ROW_W'(r);
        it.val = VAL_W'(v);
        it.ctr = CTR_W'(k);
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_items.size() > 0 || i_s_tvalid || expected_labels.size() > 0);
        // a seed may still be in flight
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int v);
        @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_DATA_W'(v);
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 0;
        case (idx)
            CFG_ROWS:    reg_rows = 8'(v & 'h1f);
            CFG_COLUMNS: reg_cols = 8'(v & 'h7f);
            CFG_CLUSTER: reg_clusters = 8'(v & 'h0f);
            default:     reg_max_it = 8'(v & 'hff);
        endcase
    endtask

    task automatic configure(int r, int c, int k, int m);
        write_reg(CFG_ROWS, r);
        write_reg(CFG_COLUMNS, c);
        write_reg(CFG_CLUSTER, k);
        write_reg(CFG_MAX_IT, m);
    endtask

    // stimulus
    initial begin
        int rows, cols, kk, random_items, random_labels, start_labels, vmax;
        i_rst_n = 0;
        i_cfg_valid = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        reg_rows = 16;
        reg_cols = 64;
        reg_clusters = 8;
        reg_max_it = 64;
        foreach (center_ok[k]) center_ok[k] = 1;
        foreach (label_mem[s]) label_mem[s] = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;

        // fill the first columns in full and seed every center from them
        for (int c = 0; c < NFILL; c++)
            for (int r = 0; r < NR; r++)
                push_item(FUNC_LOAD, c, r, $urandom_range(65535), 0);
        for (int k = 0; k < NK; k++)
            push_item(FUNC_SEED, $urandom_range(NFILL - 1), 0, 0, k);
        wait_idle();

        // smallest sizes, zero registers clamp up
        configure(0, 0, 0, 0);
        push_item(FUNC_RUN, 0, 0, 0, 0);
        wait_idle();

        // all rows and centers, out-of-range registers clamp down, one round
        configure(31, NFILL, 15, 0);
        push_item(FUNC_NONE, 63, 15, 65535, 7);
        push_item(FUNC_RUN, 0, 0, 0, 0);
        wait_idle();

        // zero column, extremes, duplicate seed that never wins
        configure(2, 4, 3, 255);
        push_item(FUNC_LOAD, 0, 0, 0, 0);
        push_item(FUNC_LOAD, 0, 1, 0, 0);
        push_item(FUNC_LOAD, 1, 0, 65535, 0);
        push_item(FUNC_LOAD, 1, 1, 65535, 0);
        push_item(FUNC_LOAD, 2, 0, 65535, 0);
        push_item(FUNC_LOAD, 2, 1, 0, 0);
        push_item(FUNC_LOAD, 3, 0, 0, 0);
        push_item(FUNC_LOAD, 3, 1, 65535, 0);
        push_item(FUNC_SEED, 1, 0, 0, 0);
        push_item(FUNC_SEED, 1, 0, 0, 1);
        push_item(FUNC_SEED, 2, 0, 0, 2);
        push_item(FUNC_RUN, 0, 0, 0, 0);
        // centers persist into the next run
        push_item(FUNC_RUN, 0, 0, 0, 0);
        wait_idle();

        // zero mass kills every center, then no valid center is left
        configure(2, 1, 3, 4);
        push_item(FUNC_RUN, 0, 0, 0, 0);
        push_item(FUNC_RUN, 0, 0, 0, 0);
        wait_idle();

        // random phases of load, seed and run sequences
        random_items = 0;
        random_labels = 0;
        for (int ph = 0; random_items < 80 || random_labels < 24; ph++) begin
            rows = $urandom_range(6, 1);
            cols = $urandom_range(NFILL, 2);
            kk = $urandom_range(4, 1);
            configure(rows, cols, kk, ($urandom_range(9) == 0) ? 255 : $urandom_range(12, 1));
            no_idle = (ph == 2);
            vmax = ($urandom_range(3) == 0) ? 15 : 65535;
            for (int c = 0; c < cols; c++)
                for (int r = 0; r < rows; r++)
                    if ($urandom_range(1)) begin
                        push_item(FUNC_LOAD, c, r,
                                  ($urandom_range(7) == 0) ? 0 : $urandom_range(vmax), 0);
                        random_items++;
                    end
            for (int n = $urandom_range(2); n > 0; n--) begin
                if ($urandom_range(1))
                    push_item(FUNC_NONE, $urandom_range(63), $urandom_range(15),
                              $urandom_range(65535), $urandom_range(7));
                else
                    push_item(FUNC_LOAD, $urandom_range(63), $urandom_range(15),
                              $urandom_range(65535), 0);
            end
            for (int k = 0; k < kk; k++)
                if ($urandom_range(4) != 0) begin
                    push_item(FUNC_SEED, $urandom_range(cols - 1), 0, 0, k);
                    random_items++;
                end
            push_item(FUNC_RUN, 0, 0, 0, 0);
            random_items++;
            start_labels = labels_seen;
            wait_idle();
            random_labels += labels_seen - start_labels;
        end
        no_idle = 0;
        repeat (200) @(posedge i_clk);

        if (mismatches == 0 && expected_labels.size() == 0)
            $display("** kmeans_l1_normalized_clusterer: PASSED **");
        else
            $display("** kmeans_l1_normalized_clusterer: FAILED **");
        $finish;
    end

    // watchdog
    initial begin
        #100_000_000;
        $display("** kmeans_l1_normalized_clusterer: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/kmc_pkg.sv
design/kmc_ram.sv
design/kmc_div.sv
design/kmc_ctrl.sv
design/kmc_dp.sv
design/kmeans_l1_normalized_clusterer.sv
bench/tb_kmeans_l1_normalized_clusterer.sv
